>>> src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define WBMP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define WBMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/wbmp_pkg.sv
// shared types and constants of the wbmp decoder
package wbmp_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam int OUT_FIELD_W = 16;
  localparam int M_TDATA_W   = 72;
  localparam int M_TUSER_W   = 3;

  localparam logic [7:0] GROUP_MASK = 8'h7f;
  localparam logic [7:0] MORE_BIT   = 8'h80;

  // one command from the parser to the result expander
  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             data;
    logic [OUT_FIELD_W-1:0] col;
    logic [OUT_FIELD_W-1:0] row;
    logic [OUT_FIELD_W-1:0] width;
    logic [OUT_FIELD_W-1:0] height;
    logic [2:0]             last_idx;
    logic                   img_done;
  } cmd_t;

endpackage

>>> src/wbmp_front.sv
// header parser and byte classifier of the wbmp decoder
module wbmp_front #(
  parameter int DIM_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             start_of_file,
  output logic             push,
  output wbmp_pkg::cmd_t   cmd,
  input  logic             q_full
);

  localparam logic [2:0] PH_TYPE   = 3'd0;
  localparam logic [2:0] PH_FIXHDR = 3'd1;
  localparam logic [2:0] PH_WIDTH  = 3'd2;
  localparam logic [2:0] PH_HEIGHT = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_ERROR  = 3'd6;

  logic [2:0]          phase, phase_next, ph;
  logic [DIM_BITS-1:0] accum, accum_next;
  logic [DIM_BITS-1:0] width, width_next;
  logic [DIM_BITS-1:0] height, height_next;
  logic [DIM_BITS-1:0] col, col_next;
  logic [DIM_BITS-1:0] row, row_next;
  logic [DIM_BITS-1:0] acc_new, left;
  logic                acc_ok, more, emit, accept, row_done, img_done, empty;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;
  assign more     = (data_byte & wbmp_pkg::MORE_BIT) != 8'd0;

  assign acc_ok   = accum[DIM_BITS-1 -: 7] == 7'd0;
  assign acc_new  = DIM_BITS'({accum, data_byte[6:0] & wbmp_pkg::GROUP_MASK[6:0]});
  assign left     = width - col;
  assign row_done = left <= DIM_BITS'(8);
  assign img_done = row_done && (({1'b0, row} + (DIM_BITS+1)'(1)) >= {1'b0, height});
  assign empty    = (width == '0) || (acc_new == '0);

  always_comb begin
    ph          = start_of_file ? PH_TYPE : phase;
    phase_next  = ph;
    accum_next  = accum;
    width_next  = width;
    height_next = height;
    col_next    = col;
    row_next    = row;
    emit        = 1'b0;
    cmd         = '0;
    unique case (ph)
      PH_TYPE: begin
        if (data_byte != 8'd0) begin
          emit       = 1'b1;
          cmd.kind   = wbmp_pkg::KIND_ERROR;
          phase_next = PH_ERROR;
        end else begin
          phase_next = PH_FIXHDR;
        end
      end
      PH_FIXHDR: begin
        if (!more) begin
          phase_next = PH_WIDTH;
          accum_next = '0;
        end
      end
      PH_WIDTH: begin
        if (!acc_ok) begin
          emit       = 1'b1;
          cmd.kind   = wbmp_pkg::KIND_ERROR;
          phase_next = PH_ERROR;
        end else if (more) begin
          accum_next = acc_new;
        end else begin
          width_next = acc_new;
          accum_next = '0;
          phase_next = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        if (!acc_ok) begin
          emit       = 1'b1;
          cmd.kind   = wbmp_pkg::KIND_ERROR;
          phase_next = PH_ERROR;
        end else if (more) begin
          accum_next = acc_new;
        end else begin
          height_next  = acc_new;
          accum_next   = '0;
          col_next     = '0;
          row_next     = '0;
          phase_next   = empty ? PH_DONE : PH_DATA;
          emit         = 1'b1;
          cmd.kind     = wbmp_pkg::KIND_HEADER;
          cmd.width    = wbmp_pkg::OUT_FIELD_W'(width);
          cmd.height   = wbmp_pkg::OUT_FIELD_W'(acc_new);
          cmd.img_done = empty;
        end
      end
      PH_DATA: begin
        emit         = 1'b1;
        cmd.kind     = wbmp_pkg::KIND_PIXEL;
        cmd.data     = data_byte;
        cmd.col      = wbmp_pkg::OUT_FIELD_W'(col);
        cmd.row      = wbmp_pkg::OUT_FIELD_W'(row);
        cmd.last_idx = row_done ? (left[2:0] - 3'd1) : 3'd7;
        cmd.img_done = img_done;
        if (row_done) begin
          col_next = '0;
          row_next = row + DIM_BITS'(1);
          if (img_done) phase_next = PH_DONE;
        end else begin
          col_next = col + DIM_BITS'(8);
        end
      end
      PH_ERROR: begin
        emit     = 1'b1;
        cmd.kind = wbmp_pkg::KIND_ERROR;
      end
      default: begin
        phase_next = ph;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_TYPE;
      accum  <= '0;
      width  <= '0;
      height <= '0;
      col    <= '0;
      row    <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      accum  <= accum_next;
      width  <= width_next;
      height <= height_next;
      col    <= col_next;
      row    <= row_next;
    end
  end

endmodule

>>> src/wbmp_queue.sv
// four-entry command queue between parser and expander
module wbmp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wbmp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output wbmp_pkg::cmd_t head,
  output logic           empty
);

  wbmp_pkg::cmd_t entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign full  = count == 3'd4;
  assign empty = count == 3'd0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      unique case ({push, pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/wbmp_back.sv
// result expander with output register of the wbmp decoder
module wbmp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  wbmp_pkg::cmd_t                head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wbmp_pkg::M_TDATA_W-1:0] out_data,
  output logic [wbmp_pkg::M_TUSER_W-1:0] out_user,
  output logic                          out_last
);

  logic [2:0] idx;
  logic       load, is_last;

  assign load    = !q_empty && (!out_valid || out_ready);
  assign is_last = idx == head.last_idx;
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: white, column, row, width, height, zero pad
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {7'd0, head.height, head.width, head.row,
                   head.col + wbmp_pkg::OUT_FIELD_W'(idx), head.data[3'd7 - idx]};
      out_user <= {is_last && head.img_done, head.kind};
      out_last <= is_last;
    end
  end

endmodule

>>> src/wbmp_type0_stream_decoder.sv
// top level of the wbmp type 0 stream decoder
// Takes a type 0 wbmp file one byte per transfer on the s_axis side (tuser high marks the
// first byte of a file and restarts the parser) and gives results on the m_axis side: one
// header transfer with width and height once the height field is complete, then one pixel
// transfer per image pixel, row by row, msb first, padding bits at row ends dropped; a bad
// type byte, a dimension of 2^DIM_BITS or more, or any byte after an error gives one error
// transfer. tlast marks the last result of an input byte; tuser bit 2 marks the result that
// completes the image. Bytes after the image give nothing until the next start of file.
// Rate: the parser takes one byte per cycle while its four-entry command queue has room;
// the expander gives one result per cycle while the receiver takes them, so a full data byte
// gives 8 results, a row-end byte as many as it has pixels, and header bytes one or none.
module wbmp_type0_stream_decoder #(
  parameter int DIM_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tuser,  // [0] start_of_file
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] pixel_white, [16:1] pixel_column, [32:17] pixel_row, [48:33] image_width,
  // [64:49] image_height, [71:65] zero
  output logic [wbmp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic [wbmp_pkg::M_TUSER_W-1:0] m_axis_tuser,  // [1:0] result_kind, [2] image_end
  output logic                           m_axis_tlast   // last_of_run
);

  wbmp_pkg::cmd_t push_cmd, head;
  logic           push, pop, q_full, q_empty;

  // parser: header fields, row and column bookkeeping
  wbmp_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .data_byte     (s_axis_tdata),
    .start_of_file (s_axis_tuser),
    .push          (push),
    .cmd           (push_cmd),
    .q_full        (q_full)
  );

  // decouples byte intake from pixel output
  wbmp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // one result per cycle into the output register while the receiver takes them
  wbmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

>>> src/wbmp_checker.sv
// port-level checker of the wbmp decoder and its bind
`include "assert_macros.svh"

module wbmp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [wbmp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [wbmp_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input logic                           m_axis_tlast
);

  `WBMP_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  `WBMP_ASSERT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  `WBMP_ASSERT(a_end_is_last, clk, rst, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast, "image end not last of run")

  `WBMP_ASSERT(a_error_clean, clk, rst, m_axis_tvalid && m_axis_tuser[1:0] == wbmp_pkg::KIND_ERROR |-> m_axis_tdata == '0 && m_axis_tlast && !m_axis_tuser[2], "error result not clean")

  `WBMP_ASSERT(a_pixel_no_dims, clk, rst, m_axis_tvalid && m_axis_tuser[1:0] == wbmp_pkg::KIND_PIXEL |-> m_axis_tdata[64:33] == '0, "pixel result carries dimensions")

endmodule

bind wbmp_type0_stream_decoder wbmp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/wbmp_type0_stream_decoder_test.sv
// testbench of the wbmp type 0 stream decoder: result tracker, byte driver and checks
`timescale 1ns / 100ps

// one result as it leaves the decoder, unpacked into its fields
typedef struct packed {
  logic [1:0]  kind;
  logic        white;
  logic [15:0] column;
  logic [15:0] row;
  logic [15:0] width;
  logic [15:0] height;
  logic        last;
  logic        img_end;
  logic [6:0]  pad;
} wbmp_result_t;

// tracks the parser state of the decoder and the results it owes
class wbmp_result_tracker;
  typedef enum logic [2:0] {
    ST_TYPE, ST_FIXHDR, ST_WIDTH, ST_HEIGHT, ST_DATA, ST_DONE, ST_ERROR
  } parse_state_t;

  parse_state_t state;
  logic [31:0]  accum;
  logic [31:0]  img_w;
  logic [31:0]  img_h;
  logic [31:0]  col_cnt;
  logic [31:0]  row_cnt;
  int unsigned  dim_bits;
  int unsigned  mismatches;
  wbmp_result_t due_results[$];

  function new(int unsigned bits);
    dim_bits = bits;
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    state = ST_TYPE;
    accum = '0;
    img_w = '0;
    img_h = '0;
    col_cnt = '0;
    row_cnt = '0;
  endfunction

  // appends one result to the owed list
  function void owe_result(wbmp_result_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  function void owe_error();
    wbmp_result_t r;
    r = '0;
    r.kind = wbmp_pkg::KIND_ERROR;
    r.last = 1'b1;
    state = ST_ERROR;
    owe_result(r);
  endfunction

  // one more 7-bit group; refused when the value would reach 2^dim_bits
  function bit take_group(logic [7:0] b);
    if ((accum >> (dim_bits - 7)) != 0) return 1'b0;
    accum = (accum << 7) | {25'd0, b[6:0]};
    return 1'b1;
  endfunction

  function void note_byte(logic [7:0] b, logic sof);
    wbmp_result_t r;
    logic [31:0] left;
    logic [31:0] n;
    bit row_done;
    bit img_done;
    bit empty;
    if (sof) restart();
    case (state)
      ST_TYPE: begin
        if (b != 8'd0) owe_error();
        else state = ST_FIXHDR;
      end
      ST_FIXHDR: begin
        // fix-header field is skipped up to its first byte without the more bit
        if ((b & wbmp_pkg::MORE_BIT) == 8'd0) begin
          state = ST_WIDTH;
          accum = '0;
        end
      end
      ST_WIDTH: begin
        if (!take_group(b)) owe_error();
        else if ((b & wbmp_pkg::MORE_BIT) == 8'd0) begin
          img_w = accum;
          accum = '0;
          state = ST_HEIGHT;
        end
      end
      ST_HEIGHT: begin
        if (!take_group(b)) owe_error();
        else if ((b & wbmp_pkg::MORE_BIT) == 8'd0) begin
          img_h = accum;
          accum = '0;
          col_cnt = '0;
          row_cnt = '0;
          empty = (img_w == 0) || (img_h == 0);
          state = empty ? ST_DONE : ST_DATA;
          r = '0;
          r.kind = wbmp_pkg::KIND_HEADER;
          r.width = img_w[15:0];
          r.height = img_h[15:0];
          r.last = 1'b1;
          r.img_end = empty;
          owe_result(r);
        end
      end
      ST_DATA: begin
        // msb first; a row ends inside this byte when fewer than 8 columns remain
        left = img_w - col_cnt;
        n = (left < 8) ? left : 32'd8;
        row_done = (n == left);
        img_done = row_done && (row_cnt + 1 >= img_h);
        for (int i = 0; i < n; i++) begin
          r = '0;
          r.kind = wbmp_pkg::KIND_PIXEL;
          r.white = b[7 - i];
          r.column = col_cnt[15:0] + 16'(i);
          r.row = row_cnt[15:0];
          r.last = (i + 1 == n);
          r.img_end = (i + 1 == n) && img_done;
          owe_result(r);
        end
        col_cnt = col_cnt + n;
        if (row_done) begin
          col_cnt = '0;
          row_cnt = row_cnt + 1;
          if (img_done) state = ST_DONE;
        end
      end
      ST_ERROR: owe_error();
      default: ;
    endcase
  endfunction

  function void report(string what, wbmp_result_t exp_r, wbmp_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected kind=%0d white=%0d col=%0d row=%0d w=%0d h=%0d last=%0d end=%0d pad=%0h",
               exp_r.kind, exp_r.white, exp_r.column, exp_r.row, exp_r.width, exp_r.height,
               exp_r.last, exp_r.img_end, exp_r.pad);
      $display("  actual   kind=%0d white=%0d col=%0d row=%0d w=%0d h=%0d last=%0d end=%0d pad=%0h",
               got.kind, got.white, got.column, got.row, got.width, got.height,
               got.last, got.img_end, got.pad);
    end
  endfunction

  function void check_result(wbmp_result_t got);
    wbmp_result_t exp_r;
    if (due_results.size() == 0) begin
      report("result with none pending", '0, got);
      return;
    end
    exp_r = due_results.pop_front();
    if (got.kind !== exp_r.kind || got.white !== exp_r.white ||
        got.column !== exp_r.column || got.row !== exp_r.row ||
        got.width !== exp_r.width || got.height !== exp_r.height ||
        got.last !== exp_r.last || got.img_end !== exp_r.img_end ||
        got.pad !== exp_r.pad)
      report("result mismatch", exp_r, got);
  endfunction

  function bit all_arrived();
    return due_results.size() == 0;
  endfunction
endclass

module wbmp_type0_stream_decoder_test;
  localparam int DIM_W = 16;
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 64;   // wait after the last drain, before the verdict

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = 8'd0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [wbmp_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic [wbmp_pkg::M_TUSER_W-1:0]  m_axis_tuser;
  logic                            m_axis_tlast;

  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 70;
  int unsigned bytes_sent = 0;
  int unsigned stall_cnt = 0;
  wbmp_result_tracker tracker;

  wbmp_type0_stream_decoder #(
    .DIM_BITS(DIM_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // input transfer noted first, so a result is never checked ahead of its byte
  always @(posedge clk) begin
    wbmp_result_t got;
    if (!rst && tracker != null) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser[1:0];
        got.img_end = m_axis_tuser[2];
        got.last = m_axis_tlast;
        got.white = m_axis_tdata[0];
        got.column = m_axis_tdata[16:1];
        got.row = m_axis_tdata[32:17];
        got.width = m_axis_tdata[48:33];
        got.height = m_axis_tdata[64:49];
        got.pad = m_axis_tdata[71:65];
        tracker.check_result(got);
      end
    end
  end

  // watchdog on cycles where nothing moves on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // one byte transfer, with random sender gaps ahead of it
  task automatic push_byte(input logic [7:0] d, input logic sof);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= sof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // sender holds off until the decoder owes nothing
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (!tracker.all_arrived());
  endtask

  // multibyte dimension, optionally led by a redundant zero group
  task automatic push_dim(input int unsigned v, input bit zero_lead);
    int unsigned groups;
    logic [7:0] b;
    groups = (v >= 16384) ? 3 : (v >= 128) ? 2 : 1;
    if (zero_lead) push_byte(wbmp_pkg::MORE_BIT, 1'b0);
    for (int i = groups - 1; i >= 0; i--) begin
      b = 8'((v >> (7 * i)) & 32'h7f);
      if (i > 0) b = b | wbmp_pkg::MORE_BIT;
      push_byte(b, 1'b0);
    end
  endtask

  // well-formed file with random content; cut short to a random prefix when asked
  task automatic push_image(input bit cut_short);
    int unsigned w;
    int unsigned h;
    int unsigned n_fix;
    int unsigned n_data;
    int unsigned keep;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      w = 0;
      h = $urandom_range(0, 5);
    end else if (pick == 1) begin
      w = $urandom_range(64, 300);
      h = 1;
    end else if (pick == 2) begin
      w = $urandom_range(16384, 65535);
      h = 0;
    end else begin
      w = $urandom_range(1, 20);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    end
    n_data = (w == 0 || h == 0) ? 0 : h * ((w + 7) / 8);
    keep = cut_short ? $urandom_range(0, n_data) : n_data;
    push_byte(8'd0, 1'b1);
    n_fix = $urandom_range(0, 2);
    repeat (n_fix) push_byte(8'($urandom_range(0, 255)) | wbmp_pkg::MORE_BIT, 1'b0);
    push_byte(8'($urandom_range(0, 255)) & wbmp_pkg::GROUP_MASK, 1'b0);
    push_dim(w, $urandom_range(0, 3) == 0);
    push_dim(h, $urandom_range(0, 3) == 0);
    repeat (keep) push_byte(8'($urandom_range(0, 255)), 1'b0);
    // trailing bytes past the image end are ignored
    if (!cut_short && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // broken file: bad type byte or oversized dimension, then up to two bytes after the error
  task automatic push_broken();
    if ($urandom_range(0, 1) == 0) begin
      push_byte(8'($urandom_range(1, 255)), 1'b1);
    end else begin
      push_byte(8'd0, 1'b1);
      push_byte(8'($urandom_range(0, 127)), 1'b0);
      if ($urandom_range(0, 1) == 0) push_dim($urandom_range(1, 20), 1'b0);
      // leading group of 4 or more overflows at the third group
      push_byte(8'($urandom_range(4, 127)) | wbmp_pkg::MORE_BIT, 1'b0);
      push_byte(8'($urandom_range(0, 255)) | wbmp_pkg::MORE_BIT, 1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) push_image(1'b0);
      else if (pick == 7) push_broken();
      else if (pick == 8) push_image(1'b1);
      else repeat ($urandom_range(1, 3))
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    tracker = new(DIM_W);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sender gaps light, receiver stalls heavy
    send_idle_pct = 22;
    recv_idle_pct = 70;

    // nonzero type byte, then a byte after the error
    push_byte(8'hff, 1'b1);
    push_byte(8'h55, 1'b0);
    // 10 x 2 image: row end inside the second byte, padding dropped
    push_byte(8'h00, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h0a, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7f, 1'b0);
    // byte after the image end
    push_byte(8'haa, 1'b0);
    // zero width: header completes the image
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h05, 1'b0);
    // widest width 65535, zero height
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h83, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'h00, 1'b0);
    // width one group too long
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h84, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);

    run_random(24);
    drain_results();

    // sender gaps heavy, receiver stalls light
    send_idle_pct = 70;
    recv_idle_pct = 22;
    run_random(22);
    drain_results();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(22);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.all_arrived()) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/wbmp_pkg.sv
src/wbmp_front.sv
src/wbmp_queue.sv
src/wbmp_back.sv
src/wbmp_type0_stream_decoder.sv
src/wbmp_checker.sv
tb/sv/wbmp_type0_stream_decoder_test.sv
